@@ hdl/trial_division_prime_counter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the trial division prime counter
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_COUNTER_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpc_pkg
// Widths, limits and control structs of the trial division prime counter.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  localparam int VALUE_W = 32;                 // signed input field
  localparam int MAG_W   = VALUE_W - 1;        // magnitude of a positive value
  localparam int DIV_W   = 16;                 // trial divisor, up to sqrt(2^31) + 2
  localparam int SQ_W    = 32;                 // square of the trial divisor
  localparam int COUNT_W = 32;
  localparam int BITCNT_W = $clog2(MAG_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DIV_W-1:0]   FIRST_ODD_DIV = DIV_W'(3);
  localparam logic [SQ_W-1:0]    FIRST_ODD_SQ  = SQ_W'(9);
  localparam logic [MAG_W-1:0]   SMALLEST_PRIME = MAG_W'(2);

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } tdpc_rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } tdpc_rem_rsp_t;

  typedef struct packed {
    logic valid;
    logic prime;
  } tdpc_res_t;

endpackage

@@ hdl/tdpc_ifs.sv @@
// ----------------------------------------------------------------------------
// tdpc channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tdpc_in_if;
  import tdpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

interface tdpc_out_if;
  import tdpc_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_prime_flag;
  logic [COUNT_W-1:0] prime_total;

  modport source (output valid, output is_prime_flag, output prime_total, input ready);
  modport sink   (input valid, input is_prime_flag, input prime_total, output ready);
endinterface

@@ hdl/tdpc_rem_unit.sv @@
// ----------------------------------------------------------------------------
// tdpc_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdpc_rem_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tdpc_pkg::tdpc_rem_req_t req,
  output tdpc_pkg::tdpc_rem_rsp_t rsp
);
  import tdpc_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0]    shift_r, shift_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    div_r, div_nxt;
  logic [DIV_W:0]      trial;

  assign trial = {rem_r, shift_r[MAG_W-1]};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = BITCNT_W'(MAG_W - 1);
      shift_nxt = req.dividend;
      rem_nxt   = '0;
      div_nxt   = req.divisor;
    end else if (busy_r) begin
      // subtract when the partial remainder covers the divisor, else keep it
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      shift_nxt = {shift_r[MAG_W-2:0], 1'b0};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

@@ hdl/tdpc_trial_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdpc_trial_ctrl
// Sequencer over odd trial divisors; tracks the divisor square incrementally.
// ----------------------------------------------------------------------------
module tdpc_trial_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [tdpc_pkg::VALUE_W-1:0] value,
  output logic                          idle,
  output tdpc_pkg::tdpc_res_t           res,
  input  logic                          res_take,
  output tdpc_pkg::tdpc_rem_req_t       rem_req,
  input  tdpc_pkg::tdpc_rem_rsp_t       rem_rsp
);
  import tdpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic             prime_r, prime_nxt;

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    prime_nxt = prime_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = mag_r;
    rem_req.divisor  = div_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mag_nxt = value[MAG_W-1:0];
          div_nxt = FIRST_ODD_DIV;
          sq_nxt  = FIRST_ODD_SQ;
          if (value[VALUE_W-1] || (value[MAG_W-1:0] < SMALLEST_PRIME)) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else if (value[MAG_W-1:0] == SMALLEST_PRIME) begin
            prime_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (!value[0]) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // stop once the divisor square passes the value
        if (sq_r > SQ_W'(mag_r)) begin
          prime_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          rem_req.start = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            div_nxt   = div_r + DIV_W'(2);
            sq_nxt    = sq_r + SQ_W'({div_r, 2'b00}) + SQ_W'(4);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r   <= mag_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.prime = prime_r;

endmodule

@@ hdl/trial_division_prime_counter_top.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_counter_top
// Trial division primality test with a saturating running count of primes.
//
//   channel   direction  payload                       transfer when
//   in_ch     sink       value (s32), restart          valid && ready
//   out_ch    source     is_prime_flag, prime_total    valid && ready
//
// An item that is below 2, equal to 2 or even needs no trial division;
// otherwise it tries k odd trial divisors in turn (k at most about 23,200
// for a 31-bit prime). Each divisor takes one bound check, a bit-serial
// remainder over the 31 magnitude bits and then the remainder result.
// Reset is synchronous and clears the prime count. A new item is taken
// while an earlier result still waits in the output register.
// ----------------------------------------------------------------------------
`include "trial_division_prime_counter_top_macros.svh"

module trial_division_prime_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  tdpc_in_if.sink     in_ch,
  tdpc_out_if.source  out_ch
);
  import tdpc_pkg::*;

  tdpc_rem_req_t      rem_req;
  tdpc_rem_rsp_t      rem_rsp;
  tdpc_res_t          res;
  logic               ctrl_idle;
  logic               in_xfer;
  logic               res_take;
  logic               restart_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] count_base;
  logic               out_valid_r;
  logic               out_prime_r;
  logic [COUNT_W-1:0] out_total_r;

  tdpc_trial_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .value    (in_ch.value),
    .idle     (ctrl_idle),
    .res      (res),
    .res_take (res_take),
    .rem_req  (rem_req),
    .rem_rsp  (rem_rsp)
  );

  tdpc_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign in_ch.ready = ctrl_idle;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign res_take    = res.valid && (!out_valid_r || out_ch.ready);

  // clear first on restart, then count with saturation
  assign count_base = restart_r ? '0 : count_r;
  always_comb begin
    count_nxt = count_base;
    if (res.prime && (count_base != COUNT_MAX)) begin
      count_nxt = count_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      restart_r <= in_ch.restart;
    end
    if (res_take) begin
      out_prime_r <= res.prime;
      out_total_r <= count_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.is_prime_flag = out_prime_r;
  assign out_ch.prime_total   = out_total_r;

  `TDPC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, !in_ch.ready,
                    "accepted item did not block input")
  `TDPC_ASSERT_NEXT(a_count_step, clk, rst_n,
                    res_take && res.prime && !restart_r && (count_r != COUNT_MAX),
                    count_r == $past(count_r) + 1'b1, "prime did not advance the count")
  `TDPC_ASSERT_NOW(a_prime_total_nonzero, clk, rst_n,
                   out_ch.valid && out_ch.is_prime_flag, out_ch.prime_total != '0,
                   "prime result with zero total")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prime counter testbench
// Sends signed 32-bit items through the trial division prime counter and
// keeps a running count of primes alongside it. Every result is compared
// field by field with the expected flag and total, in order. Directed edge
// values come first. Random traffic follows under three handshake-rate
// settings, with a long result back-pressure stretch and a full drain.
// ----------------------------------------------------------------------------
module tb;
  import tdpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2_500_000;
  localparam int BACKPRESSURE_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS = 130;

  typedef struct {
    logic               flag;
    logic [COUNT_W-1:0] total;
  } verdict_t;

  // Tracks the running prime count and the results still owed by the block.
  class PrimeCountBoard;
    verdict_t           owed_q[$];
    logic [COUNT_W-1:0] run_total;
    int                 errors;
    int                 checked;
    int                 primes_seen;

    function new();
      run_total = '0;
      errors = 0;
      checked = 0;
      primes_seen = 0;
    endfunction

    function bit prime_test(logic signed [VALUE_W-1:0] value);
      longint unsigned mag;
      longint unsigned d;
      if (value < 2) return 1'b0;
      mag = longint'(value);
      if (mag == 2) return 1'b1;
      if (mag[0] == 1'b0) return 1'b0;
      for (d = 3; d * d <= mag; d += 2) begin
        if (mag % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic signed [VALUE_W-1:0] value, logic restart);
      verdict_t v;
      if (restart) run_total = '0;
      v.flag = prime_test(value);
      if (v.flag) begin
        primes_seen++;
        if (run_total != COUNT_MAX) run_total++;
      end
      v.total = run_total;
      owed_q.push_back(v);
    endfunction

    function void check_result(logic flag, logic [COUNT_W-1:0] total);
      verdict_t v;
      if (owed_q.size() == 0) begin
        $error("unexpected result: is_prime_flag=%0b prime_total=%0d", flag, total);
        errors++;
        return;
      end
      v = owed_q.pop_front();
      checked++;
      if (flag !== v.flag) begin
        $error("is_prime_flag: expected %0b, actual %0b", v.flag, flag);
        errors++;
      end
      if (total !== v.total) begin
        $error("prime_total: expected %0d, actual %0d", v.total, total);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tdpc_in_if  in_ch();
  tdpc_out_if out_ch();

  trial_division_prime_counter_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  PrimeCountBoard board = new();

  int src_idle_pct;
  int sink_idle_pct;
  int hold_token;
  int items_sent;
  int restarts_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check each transfer, then pick next cycle's ready.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.is_prime_flag, out_ch.prime_total);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = BACKPRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Stop the run if nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Hold valid until the transfer; leave valid high for the caller.
  task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= value;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(value, restart);
    items_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    int sel;
    int unsigned m;
    int unsigned f;
    logic [VALUE_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 30) begin
      v = $urandom_range(4095, 3) | 1;
    end else if (sel < 40) begin
      v = $urandom_range(48, 0) - 8;
    end else if (sel < 55) begin
      v = $urandom & ~32'h1;
    end else if (sel < 70) begin
      v = $urandom | 32'h8000_0000;
    end else if (sel < 85) begin
      m = $urandom_range(715827882, 1);
      v = 3 * m;
    end else if (sel < 93) begin
      v = $urandom_range(65535, 4097) | 1;
    end else begin
      case ($urandom_range(3))
        0: f = 5;
        1: f = 7;
        2: f = 11;
        default: f = 13;
      endcase
      m = $urandom_range(32'h7FFF_FFFF / f, 1);
      v = f * m;
    end
    return v;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_item(random_value(), $urandom_range(9) == 0);
  endtask

  initial begin
    src_idle_pct = 15;
    sink_idle_pct = 71;
    hold_token = 0;
    items_sent = 0;
    restarts_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.restart = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edge values: non-primes below 2, squares at the divisor bound, extremes.
    send_item(32'sd0, 1'b1);
    send_item(32'sd1, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd4, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd9, 1'b0);
    send_item(32'sd15, 1'b0);
    send_item(32'sd25, 1'b0);
    send_item(32'sd49, 1'b0);
    send_item(32'sd961, 1'b0);
    send_item(32'sd97, 1'b0);
    send_item(32'sd7, 1'b1);
    send_item(32'sd8, 1'b1);
    send_item(32'sd65521, 1'b0);
    send_item(32'sd65537, 1'b0);
    send_item(32'sd2147483646, 1'b0);
    send_item(32'sd2147483645, 1'b0);
    send_item(32'sd2147483647, 1'b0);
    send_item(32'sd2, 1'b1);
    send_item(-32'sd2147483647, 1'b0);

    send_random(PHASE_ITEMS);
    drain();

    src_idle_pct = 71;
    sink_idle_pct = 15;
    send_random(PHASE_ITEMS);
    drain();

    // Back up the result side while cheap items keep coming.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_token++;
    repeat (40) send_item($urandom & ~32'h1, $urandom_range(9) == 0);
    send_random(PHASE_ITEMS);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d primes, %0d count restarts), checked %0d results",
             items_sent, board.primes_seen, restarts_sent, board.checked);
    $display("Values covered negatives, both 32-bit extremes, squares and large primes");
    if (board.pending() != 0) begin
      $error("%0d results never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
